[rtl/assert_macros.svh]
// Assertion macros used by the back end of the day-time token converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/dtts_pkg.sv]
// Package with the shared types and constants of the day-time token converter.
package dtts_pkg;

	localparam int unsigned CHAR_W = 8;
	localparam int unsigned POS_W = 4;
	localparam int unsigned DAY_W = 10;
	localparam int unsigned FIELD_W = 7;
	localparam int unsigned SECONDS_W = 25;
	localparam int unsigned ACC_W = 20;

	localparam logic [POS_W-1:0] POS_HYPHEN = 4'd3;
	localparam logic [POS_W-1:0] POS_HOUR = 4'd4;
	localparam logic [POS_W-1:0] POS_MINUTE = 4'd6;
	localparam logic [POS_W-1:0] POS_SECOND = 4'd8;
	localparam logic [POS_W-1:0] POS_LAST = 4'd9;
	localparam logic [POS_W-1:0] POS_TOKEN_LEN = 4'd10;
	localparam logic [POS_W-1:0] POS_MAX = 4'd15;

	localparam logic [CHAR_W-1:0] CHAR_HYPHEN = 8'h2d;
	localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

	localparam logic [DAY_W-1:0] DAY_MAX = 10'd366;
	localparam logic [FIELD_W-1:0] HOUR_MAX = 7'd23;
	localparam logic [FIELD_W-1:0] MINUTE_MAX = 7'd59;
	localparam logic [FIELD_W-1:0] SECOND_MAX = 7'd59;
	localparam logic [SECONDS_W-1:0] SECONDS_MAX = 25'd31622399;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QUEUE_AW = 1;
	localparam int unsigned QUEUE_CW = 2;

	typedef struct packed {
		logic ok;
		logic [DAY_W-1:0] day;
		logic [FIELD_W-1:0] hour;
		logic [FIELD_W-1:0] minute;
		logic [FIELD_W-1:0] second;
	} job_t;

endpackage

[rtl/dtts_front.sv]
// Front end: checks the form of each token and collects its day and time fields.
module dtts_front (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic [dtts_pkg::CHAR_W-1:0] char_code,
	input  logic token_end,
	input  logic queue_full,
	output logic job_push,
	output dtts_pkg::job_t job
);

	logic [dtts_pkg::POS_W-1:0] pos_q;
	logic form_ok_q;
	logic [dtts_pkg::DAY_W-1:0] day_q;
	logic [dtts_pkg::FIELD_W-1:0] hour_q;
	logic [dtts_pkg::FIELD_W-1:0] minute_q;
	logic [dtts_pkg::FIELD_W-1:0] second_q;

	logic accept;
	logic digit;
	logic [3:0] digit_val;
	logic form_nx;
	logic [dtts_pkg::POS_W-1:0] pos_nx;
	logic [dtts_pkg::DAY_W-1:0] day_nx;
	logic [dtts_pkg::FIELD_W-1:0] hour_nx;
	logic [dtts_pkg::FIELD_W-1:0] minute_nx;
	logic [dtts_pkg::FIELD_W-1:0] second_nx;

	assign accept = push && !queue_full;
	assign digit = (char_code >= dtts_pkg::CHAR_ZERO) && (char_code <= dtts_pkg::CHAR_NINE);
	assign digit_val = digit ? char_code[3:0] : 4'd0;

	always_comb begin
		form_nx = form_ok_q;
		day_nx = day_q;
		hour_nx = hour_q;
		minute_nx = minute_q;
		second_nx = second_q;
		if (pos_q >= dtts_pkg::POS_TOKEN_LEN) begin
			form_nx = 1'b0;
		end else if (pos_q == dtts_pkg::POS_HYPHEN) begin
			if (char_code != dtts_pkg::CHAR_HYPHEN) begin
				form_nx = 1'b0;
			end
		end else if (!digit) begin
			form_nx = 1'b0;
		end else if (pos_q < dtts_pkg::POS_HYPHEN) begin
			day_nx = day_q * 10'd10 + {6'd0, digit_val};
		end else if (pos_q < dtts_pkg::POS_MINUTE) begin
			hour_nx = hour_q * 7'd10 + {3'd0, digit_val};
		end else if (pos_q < dtts_pkg::POS_SECOND) begin
			minute_nx = minute_q * 7'd10 + {3'd0, digit_val};
		end else begin
			second_nx = second_q * 7'd10 + {3'd0, digit_val};
		end
		pos_nx = (pos_q == dtts_pkg::POS_MAX) ? pos_q : pos_q + 4'd1;
	end

	always_comb begin
		job.ok = form_nx && (pos_q == dtts_pkg::POS_LAST)
			&& (day_nx != '0) && (day_nx <= dtts_pkg::DAY_MAX)
			&& (hour_nx <= dtts_pkg::HOUR_MAX)
			&& (minute_nx <= dtts_pkg::MINUTE_MAX)
			&& (second_nx <= dtts_pkg::SECOND_MAX);
		job.day = day_nx;
		job.hour = hour_nx;
		job.minute = minute_nx;
		job.second = second_nx;
	end

	assign job_push = accept && token_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			form_ok_q <= 1'b1;
			day_q <= '0;
			hour_q <= '0;
			minute_q <= '0;
			second_q <= '0;
		end else if (accept) begin
			if (token_end) begin
				pos_q <= '0;
				form_ok_q <= 1'b1;
				day_q <= '0;
				hour_q <= '0;
				minute_q <= '0;
				second_q <= '0;
			end else begin
				pos_q <= pos_nx;
				form_ok_q <= form_nx;
				day_q <= day_nx;
				hour_q <= hour_nx;
				minute_q <= minute_nx;
				second_q <= second_nx;
			end
		end
	end

endmodule

[rtl/dtts_queue.sv]
// Two-entry queue of finished tokens between the front end and the back end.
module dtts_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  dtts_pkg::job_t wr_job,
	input  logic rd_en,
	output logic full,
	output logic empty,
	output dtts_pkg::job_t rd_job
);

	dtts_pkg::job_t slot_q [dtts_pkg::QUEUE_DEPTH];
	logic [dtts_pkg::QUEUE_AW-1:0] wr_ptr_q;
	logic [dtts_pkg::QUEUE_AW-1:0] rd_ptr_q;
	logic [dtts_pkg::QUEUE_CW-1:0] count_q;
	logic do_wr;
	logic do_rd;

	assign full = (count_q == dtts_pkg::QUEUE_CW'(dtts_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/dtts_back.sv]
// Back end: turns the fields of one token into seconds and holds the request for the consumer.
`include "assert_macros.svh"

module dtts_back (
	input  logic clk,
	input  logic arst_n,
	input  logic queue_empty,
	input  dtts_pkg::job_t job,
	output logic queue_pop,
	input  logic pop,
	output logic empty,
	output logic is_time,
	output logic [dtts_pkg::SECONDS_W-1:0] seconds
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MINUTE,
		ST_SECOND
	} state_t;

	state_t state_q;
	logic [dtts_pkg::ACC_W-1:0] acc_q;
	logic [dtts_pkg::FIELD_W-1:0] minute_q;
	logic [dtts_pkg::FIELD_W-1:0] second_q;
	logic ok_q;
	logic out_valid_q;
	logic out_ok_q;
	logic [dtts_pkg::SECONDS_W-1:0] out_sec_q;

	logic out_free;
	logic [dtts_pkg::ACC_W-1:0] hours_nx;
	logic [dtts_pkg::ACC_W-1:0] minutes_nx;
	logic [dtts_pkg::SECONDS_W-1:0] seconds_nx;

	assign out_free = !out_valid_q || pop;
	assign queue_pop = (state_q == ST_IDLE) && !queue_empty;

	assign hours_nx = ({10'd0, job.day} - 20'd1) * 20'd24 + {13'd0, job.hour};
	assign minutes_nx = acc_q * 20'd60 + {13'd0, minute_q};
	assign seconds_nx = {5'd0, acc_q} * 25'd60 + {18'd0, second_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			out_ok_q <= 1'b0;
			out_sec_q <= '0;
			acc_q <= '0;
			minute_q <= '0;
			second_q <= '0;
			ok_q <= 1'b0;
		end else begin
			if ((state_q == ST_SECOND) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!queue_empty) begin
						ok_q <= job.ok;
						acc_q <= job.ok ? hours_nx : '0;
						minute_q <= job.ok ? job.minute : '0;
						second_q <= job.ok ? job.second : '0;
						state_q <= ST_MINUTE;
					end
				end
				ST_MINUTE: begin
					acc_q <= minutes_nx;
					state_q <= ST_SECOND;
				end
				ST_SECOND: begin
					if (out_free) begin
						out_ok_q <= ok_q;
						out_sec_q <= seconds_nx;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign empty = !out_valid_q;
	assign is_time = out_ok_q;
	assign seconds = out_sec_q;

	`ASSERT_SAME(a_invalid_zero, out_valid_q && !out_ok_q, out_sec_q == '0, "invalid token with nonzero seconds")
	`ASSERT_SAME(a_sec_range, out_valid_q, out_sec_q <= dtts_pkg::SECONDS_MAX, "seconds out of range")
	`ASSERT_NEXT(a_wait_out, (state_q == ST_SECOND) && out_valid_q && !pop, state_q == ST_SECOND, "conversion left while output held")
	`ASSERT_NEXT(a_load, queue_pop, state_q == ST_MINUTE, "load did not start conversion")

endmodule

[rtl/day_time_token_to_seconds.sv]
// Top level of the day-time token converter: front end, queue and back end.
// Characters of a token are taken one per cycle while full is low. On the last
// character of each token one request appears on the result side: is_time tells
// whether the token had the form ddd-hhmmss with day 1-366, hour 0-23 and minutes
// and seconds 0-59, and seconds holds the seconds since the start of the year, or
// zero for an invalid token. After the last character is taken, the token passes
// through the queue and the back end's multiply-add states ST_IDLE, ST_MINUTE and
// ST_SECOND, and the result shows when the result side is free. The back end takes
// a new token from the queue only when it has finished the last one; the two-entry
// queue in front of it absorbs short tokens, and full rises only when the queue
// holds two finished tokens that the back end has not yet started.
module day_time_token_to_seconds (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic [7:0] char_code,
	input  logic token_end,
	output logic empty,
	input  logic pop,
	output logic is_time,
	output logic [24:0] seconds
);

	logic job_push;
	logic queue_full;
	logic queue_empty;
	logic queue_pop;
	dtts_pkg::job_t front_job;
	dtts_pkg::job_t head_job;

	assign full = queue_full;

	dtts_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.char_code  (char_code),
		.token_end  (token_end),
		.queue_full (queue_full),
		.job_push   (job_push),
		.job        (front_job)
	);

	dtts_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (job_push),
		.wr_job (front_job),
		.rd_en  (queue_pop),
		.full   (queue_full),
		.empty  (queue_empty),
		.rd_job (head_job)
	);

	dtts_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (queue_empty),
		.job         (head_job),
		.queue_pop   (queue_pop),
		.pop         (pop),
		.empty       (empty),
		.is_time     (is_time),
		.seconds     (seconds)
	);

endmodule
